[hdl/rtt_pkg.sv]
// Shared types and codes for the retransmit timeout tracker.
package rtt_pkg;
   localparam logic [1:0] REQ_SEND = 2'd0;
   localparam logic [1:0] REQ_DATA = 2'd1;
   localparam logic [1:0] REQ_TICK = 2'd2;

   localparam logic [2:0] EV_SENT    = 3'd0;
   localparam logic [2:0] EV_ACCEPT  = 3'd1;
   localparam logic [2:0] EV_LATE    = 3'd2;
   localparam logic [2:0] EV_OOO     = 3'd3;
   localparam logic [2:0] EV_TIMEOUT = 3'd4;
   localparam logic [2:0] EV_IDLE    = 3'd5;
   localparam logic [2:0] EV_FULL    = 3'd6;

   localparam int SEQ_W = 32;

   // controller to datapath
   typedef struct packed {
      logic load;      // latch request, start
      logic scan_clr;  // reset scan pointer
      logic scan;      // examine entry at scan pointer
      logic decide;    // settle outcome from scan
      logic comp_clr;  // reset compaction pointers
      logic comp;      // move one entry
      logic finish;    // commit scalars, load result
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_done;
      logic comp_done;
      logic need_comp;
   } sts_type;
endpackage

[hdl/rtt_ram.sv]
// Generic single-port-write, one-read RAM with registered read.
module rtt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

[hdl/rtt_ctrl.sv]
// Sequencing controller for the tracker.
module rtt_ctrl import rtt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   output cmd_type cmd,
   input  sts_type sts
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_PRE  = 3'd1;
   localparam logic [2:0] S_SCAN = 3'd2;
   localparam logic [2:0] S_DEC  = 3'd3;
   localparam logic [2:0] S_COMP = 3'd4;
   localparam logic [2:0] S_FIN  = 3'd5;
   localparam logic [2:0] S_OUT  = 3'd6;

   logic [2:0] state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         S_IDLE: if (req_tvalid) begin
            cmd.load = 1'b1;
            cmd.scan_clr = 1'b1;
            state_in = S_PRE;
         end
         S_PRE: state_in = S_SCAN;  // first read in flight
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_done) state_in = S_DEC;
         end
         S_DEC: begin
            cmd.decide = 1'b1;
            cmd.comp_clr = 1'b1;
            state_in = S_COMP;
         end
         S_COMP: begin
            if (!sts.need_comp || sts.comp_done) state_in = S_FIN;
            else cmd.comp = 1'b1;
         end
         S_FIN: begin
            cmd.finish = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: if (rsp_tready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end
endmodule

[hdl/rtt_dp.sv]
// Datapath: queue memories, scan, compaction and scalar state.
module rtt_dp import rtt_pkg::*; #(
   parameter int PENDING_DEPTH = 16,
   parameter int TIME_WIDTH    = 40,
   parameter int TIMEOUT_WIDTH = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cfg_we,
   input  logic [23:0]                   cfg_data,
   input  logic [1:0]                    in_type,
   input  logic [SEQ_W-1:0]              in_seq,
   input  cmd_type                       cmd,
   output sts_type                       sts,
   output logic [2:0]                    o_code,
   output logic [SEQ_W-1:0]              o_seq,
   output logic [TIMEOUT_WIDTH-1:0]      o_timeout,
   output logic [SEQ_W-1:0]              o_next,
   output logic [$clog2(PENDING_DEPTH+1)-1:0] o_total
);
   localparam int AW = $clog2(PENDING_DEPTH);
   localparam int CW = $clog2(PENDING_DEPTH+1);
   localparam logic [TIMEOUT_WIDTH-1:0] TO_MAX = '1;

   logic [1:0]               type_ff;
   logic [SEQ_W-1:0]         dseq_ff;
   logic [CW-1:0]            total_ff;
   logic [SEQ_W-1:0]         next_ff;
   logic [TIMEOUT_WIDTH-1:0] tout_ff;
   logic [1:0]               run_ff;
   logic [TIME_WIDTH-1:0]    time_ff;
   logic [CW-1:0]            rd_ff;   // scan / compaction read pointer
   logic [CW-1:0]            wr_ff;   // compaction write pointer
   logic                     found_ff;
   logic [CW-1:0]            pos_ff;
   logic [TIME_WIDTH-1:0]    best_ff;
   logic [SEQ_W-1:0]         gone_ff;
   logic [2:0]               code_ff;
   logic [SEQ_W-1:0]         eseq_ff;

   logic [SEQ_W-1:0]      num_rd;
   logic [TIME_WIDTH-1:0] dl_rd;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [SEQ_W-1:0]      wr_num;
   logic [TIME_WIDTH-1:0] wr_dl;
   logic [CW-1:0]         rd_addr_full;
   logic [CW-1:0]         idx;     // index of entry whose data is on num_rd
   logic                  full;
   logic                  keep;
   logic                  comp_step;

   assign full = (total_ff >= CW'(PENDING_DEPTH));
   assign idx = rd_ff - CW'(1);

   // data on the read port belongs to the entry one below rd_ff
   always_comb begin
      rd_addr_full = rd_ff;
      if (cmd.scan_clr || cmd.comp_clr) rd_addr_full = '0;
   end

   rtt_ram #(.WIDTH(SEQ_W), .DEPTH(PENDING_DEPTH)) u_num (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_num),
      .rd_addr(rd_addr_full[AW-1:0]), .rd_data(num_rd));
   rtt_ram #(.WIDTH(TIME_WIDTH), .DEPTH(PENDING_DEPTH)) u_dl (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_dl),
      .rd_addr(rd_addr_full[AW-1:0]), .rd_data(dl_rd));

   // compaction writes only when rd_ff>0 (data of idx present)
   assign comp_step = cmd.comp && rd_ff != '0;

   // compaction keeps entries after the match (data) or above gone (tick)
   always_comb begin
      if (type_ff == REQ_DATA) keep = (idx > pos_ff);
      else keep = (num_rd > gone_ff);
   end

   always_comb begin
      wr_en = 1'b0;
      wr_addr = total_ff[AW-1:0];
      wr_num = next_ff;
      wr_dl = time_ff + TIME_WIDTH'(tout_ff);
      if (cmd.decide && type_ff == REQ_SEND && !full) wr_en = 1'b1;
      else if (comp_step && keep) begin
         wr_en = 1'b1;
         wr_addr = wr_ff[AW-1:0];
         wr_num = num_rd;
         wr_dl = dl_rd;
      end
   end

   // scan: rd_ff counts entries examined+1; data at idx valid when rd_ff>0
   assign sts.scan_done = (type_ff != REQ_DATA && type_ff != REQ_TICK) ||
                          (rd_ff > total_ff) ||
                          (type_ff == REQ_DATA && found_ff);
   assign sts.comp_done = (rd_ff > total_ff);
   assign sts.need_comp = (code_ff == EV_ACCEPT) || (code_ff == EV_OOO) ||
                          (code_ff == EV_TIMEOUT);

   logic [TIME_WIDTH-1:0] now;
   assign now = time_ff;

   always_ff @(posedge clock) begin
      if (reset) time_ff <= '0;
      else if (cmd.load && in_type == REQ_TICK) time_ff <= time_ff + TIME_WIDTH'(1);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         type_ff <= in_type;
         dseq_ff <= in_seq;
         found_ff <= 1'b0;
      end
      if (cmd.scan_clr) rd_ff <= '0;
      else if (cmd.comp_clr) rd_ff <= '0;
      else if (cmd.scan) begin
         rd_ff <= rd_ff + CW'(1);
         if (rd_ff != '0 && idx < total_ff) begin
            if (type_ff == REQ_DATA && !found_ff && num_rd == dseq_ff) begin
               found_ff <= 1'b1;
               pos_ff <= idx;
            end
            if (type_ff == REQ_TICK && dl_rd <= now &&
                (!found_ff || dl_rd < best_ff)) begin
               found_ff <= 1'b1;
               pos_ff <= idx;
               best_ff <= dl_rd;
               gone_ff <= num_rd;
            end
         end
      end else if (cmd.comp) begin
         rd_ff <= rd_ff + CW'(1);
         if (comp_step && keep) wr_ff <= wr_ff + CW'(1);
      end
      if (cmd.comp_clr) wr_ff <= '0;

      if (cmd.decide) begin
         unique case (type_ff)
            REQ_SEND: begin
               code_ff <= full ? EV_FULL : EV_SENT;
               eseq_ff <= next_ff;
            end
            REQ_DATA: begin
               eseq_ff <= dseq_ff;
               if (!found_ff) code_ff <= EV_LATE;
               else if (pos_ff != '0) code_ff <= EV_OOO;
               else code_ff <= EV_ACCEPT;
            end
            REQ_TICK: begin
               if (found_ff) begin
                  code_ff <= EV_TIMEOUT;
                  eseq_ff <= gone_ff;
               end else begin
                  code_ff <= EV_IDLE;
                  eseq_ff <= '0;
               end
            end
            default: begin
               code_ff <= EV_IDLE;
               eseq_ff <= '0;
            end
         endcase
      end
   end

   logic [TIMEOUT_WIDTH+1:0] cut;
   assign cut = ({2'b0, tout_ff} * (TIMEOUT_WIDTH+2)'(3)) >> 2;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         next_ff <= '0;
         run_ff <= '0;
         tout_ff <= TIMEOUT_WIDTH'(100);
      end else begin
         if (cfg_we) begin
            if (cfg_data == '0) tout_ff <= TIMEOUT_WIDTH'(1);
            else if (32'(cfg_data) > 32'(TO_MAX)) tout_ff <= TO_MAX;
            else tout_ff <= TIMEOUT_WIDTH'(cfg_data);
         end
         if (cmd.decide && type_ff == REQ_SEND && !full) begin
            total_ff <= total_ff + CW'(1);
            next_ff <= next_ff + SEQ_W'(1);
         end
         if (cmd.finish) begin
            if (sts.need_comp) total_ff <= wr_ff;
            unique case (code_ff)
               EV_LATE: next_ff <= dseq_ff;
               EV_OOO: begin
                  next_ff <= dseq_ff;
                  run_ff <= '0;
               end
               EV_ACCEPT: begin
                  if (run_ff == 2'd2) begin
                     run_ff <= '0;
                     tout_ff <= (cut == '0) ? TIMEOUT_WIDTH'(1) : cut[TIMEOUT_WIDTH-1:0];
                  end else run_ff <= run_ff + 2'd1;
               end
               EV_TIMEOUT: begin
                  next_ff <= gone_ff;
                  run_ff <= '0;
                  tout_ff <= tout_ff[TIMEOUT_WIDTH-1] ? TO_MAX : {tout_ff[TIMEOUT_WIDTH-2:0], 1'b0};
               end
               default: ;
            endcase
         end
      end
   end

   assign o_code = code_ff;
   assign o_seq = eseq_ff;
   assign o_timeout = tout_ff;
   assign o_next = next_ff;
   assign o_total = total_ff;
endmodule

[hdl/retransmit_timeout_tracker.sv]
// Top level of the retransmit timeout tracker.
//  channel | dir | contents
//  req     | in  | tuser=req_type, tdata=data_seq
//  rsp     | out | tuser=event_code, tdata=seq,timeout,upcoming,outstanding
//  csr     | in  | initial_timeout write
// A tick that times out an entry, or matched data, walks the queue memories
// once to scan and once to compact; late data and an idle tick only scan,
// and a send or an unused kind does neither.
// Reset is synchronous; the result is held until rsp_tready, and no new
// transaction is taken meanwhile.
module retransmit_timeout_tracker import rtt_pkg::*; #(
   parameter int PENDING_DEPTH = 16,
   parameter int TIME_WIDTH    = 40,
   parameter int TIMEOUT_WIDTH = 24
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,  // data_seq
   input  logic [1:0]   req_tuser,  // req_type
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // event_seq, timeout_now, upcoming_seq, outstanding
   output logic [((71+TIMEOUT_WIDTH+$clog2(PENDING_DEPTH+1))/8)*8-1:0] rsp_tdata,
   output logic [2:0]   rsp_tuser,  // event_code
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [23:0]  csr_data
);
   localparam int CW = $clog2(PENDING_DEPTH+1);
   localparam int TDW = ((71 + TIMEOUT_WIDTH + CW) / 8) * 8;
   cmd_type cmd;
   sts_type sts;
   logic [SEQ_W-1:0] o_seq, o_next;
   logic [TIMEOUT_WIDTH-1:0] o_to;
   logic [CW-1:0] o_total;

   assign csr_ready = 1'b1;

   rtt_ctrl u_ctrl (.clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid,
      .rsp_tready, .cmd, .sts);
   rtt_dp #(.PENDING_DEPTH(PENDING_DEPTH), .TIME_WIDTH(TIME_WIDTH),
      .TIMEOUT_WIDTH(TIMEOUT_WIDTH)) u_dp (
      .clock, .reset, .cfg_we(csr_valid), .cfg_data(csr_data),
      .in_type(req_tuser), .in_seq(req_tdata), .cmd, .sts,
      .o_code(rsp_tuser), .o_seq, .o_timeout(o_to), .o_next,
      .o_total);

   assign rsp_tdata = TDW'({o_total, o_next, o_to, o_seq});
endmodule

[hdl/rtt_checker.sv]
// Port-level checks for the tracker, bound to the top level.
module rtt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [2:0]  rsp_tuser
);
   a_one: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid)) else $error("ready while result held");
   a_acc: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !rsp_tvalid && !req_tready) else $error("no work");
   a_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser != 3'd7) else $error("bad code");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tuser)) else $error("drop");
endmodule

bind retransmit_timeout_tracker rtt_checker u_chk (.clock, .reset, .req_tvalid,
   .req_tready, .rsp_tvalid, .rsp_tready, .rsp_tuser);
